// ----- hdl/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int OCC_W     = 5;
    localparam int STAT_W    = 2;

    // action codes carried on s_tuser
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    // result status carried on m_tuser
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                      valid;
        logic                      take;   // new value belongs here or to the left
        logic signed [VALUE_W-1:0] entry;
    } cell_link_t;

    // broadcast command to every cell
    typedef struct packed {
        logic                      shift_in;   // accepted insert, queue not full
        logic                      shift_out;  // accepted remove, queue not empty
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- hdl/min_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// min_priority_queue_top
// Bounded queue of signed priorities kept in ascending order in a chain of
// cells. Insert places a value after equal entries; remove returns the head.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser
//  ---------+-----+--------------------------------+-------------------
//  s_       | in  | [31:0] value                   | [0] action
//  m_       | out | [31:0] removed_value,          | [1:0] status
//           |     | [36:32] occupancy, [39:37] 0   |
//
//  One beat per cycle sustained; an accepted item updates the chain and loads
//  the output register at the same edge, so its result is offered the cycle
//  after acceptance.
//  Every cell compares the broadcast value in parallel and shifts in the
//  same edge. s_tready drops only while a result waits on a stalled m_tready.
//  Synchronous reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module min_priority_queue_top #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    mpq_pkg::cell_link_t link [DEPTH];
    mpq_pkg::cell_cmd_t  cmd;

    logic                               accept;
    logic                               is_remove;
    logic                               full;
    logic                               empty;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    mpq_pkg::status_t                   status;
    logic signed [mpq_pkg::VALUE_W-1:0] removed;

    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [39:0]                        m_data_reg;
    logic [1:0]                         m_user_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_remove = (mpq_pkg::action_t'(s_tuser[0]) == mpq_pkg::ACT_REMOVE);
    assign full      = link[DEPTH-1].valid;
    assign empty     = !link[0].valid;

    assign cmd.shift_in  = accept && !is_remove && !full;
    assign cmd.shift_out = accept && is_remove && !empty;
    assign cmd.value     = $signed(s_tdata[mpq_pkg::VALUE_W-1:0]);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            mpq_pkg::cell_link_t left_l;
            mpq_pkg::cell_link_t right_l;
            if (g == 0) begin : g_head
                // left edge: always valid, never an insertion point
                assign left_l = '{valid: 1'b1, take: 1'b0, entry: '0};
            end else begin : g_mid_l
                assign left_l = link[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_l = '{valid: 1'b0, take: 1'b1, entry: '0};
            end else begin : g_mid_r
                assign right_l = link[g+1];
            end
            mpq_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .left    (left_l),
                .right   (right_l),
                .self    (link[g])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        status     = mpq_pkg::STAT_OK;
        removed    = '0;
        if (accept) begin
            if (is_remove) begin
                if (empty) begin
                    status = mpq_pkg::STAT_EMPTY;
                end else begin
                    removed    = link[0].entry;
                    count_next = count_reg - CNT_W'(1);
                end
            end else begin
                if (full) begin
                    status = mpq_pkg::STAT_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {3'b000, mpq_pkg::OCC_W'(count_next), removed};
            m_user_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- hdl/mpq_cell.sv -----
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds an entry and a valid flag, shifts right
// on insert past the insertion point and shifts left on remove.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  mpq_pkg::cell_cmd_t  cmd,
    input  mpq_pkg::cell_link_t left,
    input  mpq_pkg::cell_link_t right,
    output mpq_pkg::cell_link_t self
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [mpq_pkg::VALUE_W-1:0] entry_reg;
    logic signed [mpq_pkg::VALUE_W-1:0] entry_next;
    logic                              take;

    // strict compare keeps equal entries ahead of the new one
    assign take = !valid_reg || (cmd.value < entry_reg);

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.shift_in) begin
            if (take) begin
                entry_next = left.take ? left.entry : cmd.value;
                valid_next = valid_reg || left.valid;
            end
        end else if (cmd.shift_out) begin
            entry_next = right.entry;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign self.valid = valid_reg;
    assign self.take  = take;
    assign self.entry = entry_reg;

endmodule

// ----- hdl/mpq_checker.sv -----
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [mpq_pkg::OCC_W-1:0] FULL_OCC = mpq_pkg::OCC_W'(DEPTH);

    // held result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a remove on an empty queue reports nothing removed and an empty queue
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mpq_pkg::STAT_EMPTY) |-> (m_tdata == 40'd0))
        else $error("empty status with nonzero data");

    // a refused insert means the queue sits at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mpq_pkg::STAT_FULL)
        |-> (m_tdata[36:32] == FULL_OCC) && (m_tdata[31:0] == 32'd0))
        else $error("full status with wrong occupancy or data");

    // every accepted item yields a result beat on the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

endmodule

bind min_priority_queue_top mpq_checker #(.DEPTH(DEPTH)) u_mpq_checker (.*);
